// ----- rtl/core/crlf_pkg.sv -----
// Package for the CRLF message framer: constants, word types, register map.
package crlf_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 256;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_END_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       parity_bad;
		logic       framing_bad;
	} rx_word_t;

	typedef struct packed {
		logic       store_enable;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       message_done;
		logic [8:0] message_length;
		logic       parity_error_seen;
		logic       framing_error_seen;
		logic       overflow;
	} res_word_t;

endpackage

// ----- rtl/core/crlf_framer_core.sv -----
// Message state registers and per-word delimiter, index and length logic.
module crlf_framer_core #(
	parameter int unsigned BUFFER_BYTES = crlf_pkg::BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                end_mode,
	input  crlf_pkg::rx_word_t  rx_word,
	output crlf_pkg::res_word_t res_word
);
	import crlf_pkg::*;

	localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned WW = (CW > 9) ? CW : 9;

	logic [CW-1:0] fill_q;
	logic [7:0]    recent_q [3];
	logic          header_q;
	logic          parity_q;
	logic          framing_q;

	logic          full;
	logic          crlf;
	logic          restart;
	logic          done;
	logic          ovf;
	logic          par_acc;
	logic          frm_acc;
	logic [CW-1:0] fill_next;
	logic [WW-1:0] pos_w;
	logic [WW-1:0] len_w;

	always_comb begin
		full    = (fill_q == CW'(BUFFER_BYTES));
		crlf    = (recent_q[0] == CH_CR) && (rx_word.rx_byte == CH_LF);
		restart = 1'b0;
		done    = 1'b0;
		if (!end_mode) begin
			if ((fill_q != '0) && crlf) begin
				if (!header_q) begin
					restart = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		end else begin
			if ((fill_q >= CW'(3)) && crlf && (recent_q[2] == CH_CR)
					&& (recent_q[1] == CH_LF)) begin
				done = 1'b1;
			end
		end
		ovf     = full && !restart;
		done    = done || ovf;
		par_acc = parity_q || rx_word.parity_bad;
		frm_acc = framing_q || rx_word.framing_bad;

		if (restart) begin
			fill_next = '0;
		end else if (full) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + CW'(1);
		end

		pos_w = WW'(fill_q);
		len_w = WW'(fill_next);

		res_word = '0;
		if (!full) begin
			res_word.store_enable = 1'b1;
			res_word.store_index  = pos_w[7:0];
			res_word.store_byte   = rx_word.rx_byte;
		end
		if (done) begin
			res_word.message_done       = 1'b1;
			res_word.message_length     = len_w[8:0];
			res_word.parity_error_seen  = par_acc;
			res_word.framing_error_seen = frm_acc;
			res_word.overflow           = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			recent_q[2] <= '0;
			header_q    <= 1'b0;
			parity_q    <= 1'b0;
			framing_q   <= 1'b0;
		end else if (step) begin
			if (done) begin
				fill_q      <= '0;
				recent_q[0] <= '0;
				recent_q[1] <= '0;
				recent_q[2] <= '0;
				header_q    <= 1'b0;
				parity_q    <= 1'b0;
				framing_q   <= 1'b0;
			end else begin
				fill_q      <= fill_next;
				recent_q[0] <= rx_word.rx_byte;
				recent_q[1] <= recent_q[0];
				recent_q[2] <= recent_q[1];
				header_q    <= header_q || restart;
				parity_q    <= par_acc;
				framing_q   <= frm_acc;
			end
		end
	end

endmodule

// ----- rtl/core/crlf_message_framer_top.sv -----
// Top level of the CRLF message framer: register port, framer core, result register.
//
//  channel   direction  handshake              payload
//  rx        in         rx_valid / rx_ready    rx_word  (crlf_pkg::rx_word_t)
//  res       out        res_valid / res_ready  res_word (crlf_pkg::res_word_t)
//  config    in         psel/penable/pready    paddr, pwdata, prdata (end_mode at 0x0)
//
// One word per cycle while the result is not stalled; each word gives one result in the cycle after it is taken.
// The result register is the only stage; rx_ready is high whenever it is empty
// or being drained in the same cycle.
// Reset clears message state, end_mode and the result valid bit.
// A stalled result holds res_word and blocks further rx words.
module crlf_message_framer_top #(
	parameter int unsigned BUFFER_BYTES = crlf_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rx_valid,
	output logic                                rx_ready,
	input  crlf_pkg::rx_word_t                  rx_word,
	output logic                                res_valid,
	input  logic                                res_ready,
	output crlf_pkg::res_word_t                 res_word,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crlf_pkg::PADDR_W-1:0]        paddr,
	input  logic [crlf_pkg::PDATA_W-1:0]        pwdata,
	output logic [crlf_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import crlf_pkg::*;

	logic      end_mode_q;
	logic      res_valid_q;
	res_word_t res_word_q;
	res_word_t step_res;
	logic      rx_take;

	assign pready   = 1'b1;
	assign rx_ready = !res_valid_q || res_ready;
	assign rx_take  = rx_valid && rx_ready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_END_MODE) begin
			prdata[0] = end_mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_END_MODE)) begin
			end_mode_q <= pwdata[0];
		end
	end

	crlf_framer_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (rx_take),
		.end_mode(end_mode_q),
		.rx_word (rx_word),
		.res_word(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_ready) begin
			res_valid_q <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			res_word_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule
